/* design/u8d_pkg.sv */
// Shared types, byte-range constants and the code page 1252 mapping for the
// UTF-8 validating decoder. No dependencies.

package u8d_pkg;

   // Transaction payloads
   typedef struct packed {
      logic [7:0] data_byte;
      logic       stream_end;
   } req_type;

   typedef struct packed {
      logic [20:0] char_value;
      logic        malformed;
      logic        run_last;
   } rsp_type;

   // One input byte's worth of results: cnt results, all replacements except
   // that the last one carries good_val when good is set.
   typedef struct packed {
      logic [2:0]  cnt;
      logic        good;
      logic [20:0] good_val;
   } burst_type;

   // Register indexes
   localparam logic CSR_OUTPUT_MODE      = 1'b0;
   localparam logic CSR_REPLACEMENT_CODE = 1'b1;

   localparam logic [20:0] REPLACEMENT_RESET = 21'h00FFFD;
   localparam logic [20:0] QMARK             = 21'h00003F;

   // Lead byte ranges
   localparam logic [7:0] ASCII_TOP = 8'h7F;
   localparam logic [7:0] LEAD2_LO  = 8'hC2;
   localparam logic [7:0] LEAD2_HI  = 8'hDF;
   localparam logic [7:0] LEAD3_LO  = 8'hE0;
   localparam logic [7:0] LEAD3_HI  = 8'hEF;
   localparam logic [7:0] LEAD4_LO  = 8'hF0;
   localparam logic [7:0] LEAD4_HI  = 8'hF4;
   localparam logic [7:0] LEAD_ED   = 8'hED;

   // Continuation bounds
   localparam logic [7:0] CONT_LO     = 8'h80;
   localparam logic [7:0] CONT_HI     = 8'hBF;
   localparam logic [7:0] AFTER_E0_LO = 8'hA0;
   localparam logic [7:0] AFTER_ED_HI = 8'h9F;
   localparam logic [7:0] AFTER_F0_LO = 8'h90;
   localparam logic [7:0] AFTER_F4_HI = 8'h8F;

   // Code points of bytes 0x80-0x9F in code page 1252
   localparam logic [15:0] CP1252_UPPER [32] = '{
      16'h20AC, 16'h0081, 16'h201A, 16'h0192, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
      16'h02C6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'h008D, 16'h017D, 16'h008F,
      16'h0090, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
      16'h02DC, 16'h2122, 16'h0161, 16'h203A, 16'h0153, 16'h009D, 16'h017E, 16'h0178
   };

   // Code point to code page 1252 byte, '?' when there is none
   function automatic logic [20:0] to_cp1252(input logic [20:0] cp);
      logic [20:0] res;
      res = QMARK;
      if (cp < 21'h80 || (cp >= 21'hA0 && cp <= 21'hFF)) begin
         res = cp;
      end else begin
         for (int k = 0; k < 32; k++) begin
            if ({5'd0, CP1252_UPPER[k]} == cp) begin
               res = 21'h80 | 21'(k);
            end
         end
      end
      return res;
   endfunction

endpackage

/* design/utf8_validating_decoder.sv */
// Top level of the UTF-8 validating decoder: configuration registers, burst
// register and output register. Depends on u8d_pkg and u8d_decode.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_data  (data_byte, stream_end)
//   rsp      out        rsp_valid/rsp_stall  rsp_data  (char_value, malformed, run_last)
//   csr      in         csr_we               csr_index, csr_wdata
//
// One byte is taken per cycle while req_stall is low; a byte that yields n results (0 to 4)
// stalls the input (not for 0 or 1, unless rsp_stall holds the drain) while the burst
// register drains one result a cycle whenever the output register can take it.
// The output register lets a new byte enter while a result waits on rsp_stall.
// Each result passes through the burst register and then the output register.
// Synchronous reset clears the sequence state, both registers' valid state and
// the configuration (mode 0, replacement U+FFFD).

module utf8_validating_decoder (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  u8d_pkg::req_type   req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output u8d_pkg::rsp_type   rsp_data,
   input  logic               csr_we,
   input  logic               csr_index,
   input  logic [20:0]        csr_wdata
);
   import u8d_pkg::*;

   logic        mode_ff;
   logic [20:0] rep_ff;
   logic [20:0] rep_mapped;

   logic [2:0]  a_cnt_ff, a_cnt_in;
   logic        a_good_ff;
   logic [20:0] a_gval_ff;
   logic        out_valid_ff, out_valid_in;
   rsp_type     out_data_ff, out_data_in;

   logic        b_ready;
   logic        a_move;
   logic        req_accept;
   logic        item_good;
   burst_type   burst;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
         rep_ff  <= REPLACEMENT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_OUTPUT_MODE:      mode_ff <= csr_wdata[0];
            CSR_REPLACEMENT_CODE: rep_ff  <= csr_wdata;
            default:              ;
         endcase
      end
   end

   assign rep_mapped = mode_ff ? to_cp1252(rep_ff) : rep_ff;

   // Handshake
   assign b_ready    = !out_valid_ff || !rsp_stall;
   assign a_move     = (a_cnt_ff != 3'd0) && b_ready;
   assign req_stall  = !((a_cnt_ff == 3'd0) || (a_cnt_ff == 3'd1 && b_ready));
   assign req_accept = req_valid && !req_stall;

   u8d_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .accept     (req_accept),
      .data_byte  (req_data.data_byte),
      .stream_end (req_data.stream_end),
      .mode       (mode_ff),
      .burst      (burst)
   );

   // Burst register: results still owed for the last byte
   always_comb begin
      a_cnt_in = a_cnt_ff;
      if (a_move) a_cnt_in = a_cnt_ff - 3'd1;
      if (req_accept) a_cnt_in = burst.cnt;
   end

   // Next result item from the burst
   assign item_good = (a_cnt_ff == 3'd1) && a_good_ff;

   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (a_move) begin
         out_valid_in           = 1'b1;
         out_data_in.char_value = item_good ? a_gval_ff : rep_mapped;
         out_data_in.malformed  = !item_good;
         out_data_in.run_last   = (a_cnt_ff == 3'd1);
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_cnt_ff     <= 3'd0;
         out_valid_ff <= 1'b0;
      end else begin
         a_cnt_ff     <= a_cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         a_good_ff <= burst.good;
         a_gval_ff <= burst.good_val;
      end
      out_data_ff <= out_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

/* design/u8d_decode.sv */
// Sequence tracker of the UTF-8 decoder: holds the open-sequence state and
// turns each accepted byte into a result burst. Depends on u8d_pkg.

module u8d_decode (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [7:0]           data_byte,
   input  logic                 stream_end,
   input  logic                 mode,
   output u8d_pkg::burst_type   burst
);
   import u8d_pkg::*;

   logic [1:0]  rem_ff, rem_in;
   logic [1:0]  acc_ff, acc_in;
   logic [20:0] part_ff, part_in;
   logic [7:0]  lo_ff, lo_in;
   logic [7:0]  hi_ff, hi_in;

   logic        in_seq;
   logic        in_bounds;
   logic [20:0] part_ext;
   logic [1:0]  rem_dec;
   logic [2:0]  pre_cnt;
   logic [20:0] raw_val;

   assign in_seq    = (rem_ff != 2'd0);
   assign in_bounds = (data_byte >= lo_ff) && (data_byte <= hi_ff);
   assign part_ext  = {part_ff[14:0], data_byte[5:0]};
   assign rem_dec   = rem_ff - 2'd1;

   // Next state and burst for this byte
   always_comb begin
      rem_in     = 2'd0;
      acc_in     = 2'd0;
      part_in    = 21'd0;
      lo_in      = CONT_LO;
      hi_in      = CONT_HI;
      burst.cnt  = 3'd0;
      burst.good = 1'b0;
      raw_val    = 21'd0;
      pre_cnt    = 3'd0;
      if (in_seq && in_bounds) begin
         if (rem_dec == 2'd0) begin
            // sequence complete
            burst.cnt  = 3'd1;
            burst.good = 1'b1;
            raw_val    = part_ext;
         end else if (stream_end) begin
            // truncated: replace every byte taken
            burst.cnt = {1'b0, acc_ff} + 3'd1;
         end else begin
            rem_in  = rem_dec;
            acc_in  = acc_ff + 2'd1;
            part_in = part_ext;
         end
      end else begin
         // flush a broken sequence, then treat the byte as a lead
         pre_cnt = in_seq ? {1'b0, acc_ff} : 3'd0;
         if (data_byte <= ASCII_TOP) begin
            burst.cnt  = pre_cnt + 3'd1;
            burst.good = 1'b1;
            raw_val    = {13'd0, data_byte};
         end else if (data_byte inside {[LEAD2_LO:LEAD2_HI], [LEAD3_LO:LEAD3_HI],
                                        [LEAD4_LO:LEAD4_HI]}) begin
            if (stream_end) begin
               burst.cnt = pre_cnt + 3'd1;
            end else begin
               burst.cnt = pre_cnt;
               acc_in    = 2'd1;
               if (data_byte <= LEAD2_HI) begin
                  rem_in  = 2'd1;
                  part_in = {16'd0, data_byte[4:0]};
               end else if (data_byte <= LEAD3_HI) begin
                  rem_in  = 2'd2;
                  part_in = {17'd0, data_byte[3:0]};
                  if (data_byte == LEAD3_LO) lo_in = AFTER_E0_LO;
                  if (data_byte == LEAD_ED)  hi_in = AFTER_ED_HI;
               end else begin
                  rem_in  = 2'd3;
                  part_in = {18'd0, data_byte[2:0]};
                  if (data_byte == LEAD4_LO) lo_in = AFTER_F0_LO;
                  if (data_byte == LEAD4_HI) hi_in = AFTER_F4_HI;
               end
            end
         end else begin
            // invalid lead
            burst.cnt = pre_cnt + 3'd1;
         end
      end
      burst.good_val = mode ? to_cp1252(raw_val) : raw_val;
   end

   // Sequence state
   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff  <= 2'd0;
         acc_ff  <= 2'd0;
         part_ff <= 21'd0;
         lo_ff   <= CONT_LO;
         hi_ff   <= CONT_HI;
      end else if (accept) begin
         rem_ff  <= rem_in;
         acc_ff  <= acc_in;
         part_ff <= part_in;
         lo_ff   <= lo_in;
         hi_ff   <= hi_in;
      end
   end

endmodule

/* design/u8d_checker.sv */
// Port-level checks for the UTF-8 validating decoder, bound to the top level.
// Depends on u8d_pkg and utf8_validating_decoder.

module u8d_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  u8d_pkg::rsp_type   rsp_data
);
   import u8d_pkg::*;

   // A stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   // A stalled result does not change
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_data))
      else $error("rsp_data changed while stalled");

   // A decoded character always closes its byte's run
   a_good_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.malformed |-> rsp_data.run_last)
      else $error("well-formed result not marked run_last");

   // No result right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered after reset");

endmodule

bind utf8_validating_decoder u8d_checker u_checker (.*);

/* tb/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for utf8_validating_decoder: a directed byte table, then
// random UTF-8 streams under changing settings, checked against a behavioral decoder.
// Depends on u8d_pkg and the decoder RTL.

module tb;
   import u8d_pkg::*;

   localparam int HALF_PERIOD  = 10;
   localparam int RESET_CYCLES = 7;
   localparam int DRAIN_CYCLES = 8;
   localparam int HOLD_CYCLES  = 300;
   localparam int PHASE_ITEMS  = 54;
   localparam int NUM_PHASES   = 6;
   localparam int CYCLE_LIMIT  = 200000;

   // Code points of bytes 0x80-0x9F in code page 1252
   localparam logic [20:0] CP1252_HIGH [32] = '{
      21'h20AC, 21'h0081, 21'h201A, 21'h0192, 21'h201E, 21'h2026, 21'h2020, 21'h2021,
      21'h02C6, 21'h2030, 21'h0160, 21'h2039, 21'h0152, 21'h008D, 21'h017D, 21'h008F,
      21'h0090, 21'h2018, 21'h2019, 21'h201C, 21'h201D, 21'h2022, 21'h2013, 21'h2014,
      21'h02DC, 21'h2122, 21'h0161, 21'h203A, 21'h0153, 21'h009D, 21'h017E, 21'h0178
   };

   // Settings per random phase: mode and replacement code point
   localparam logic        PHASE_MODE [NUM_PHASES] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1};
   localparam logic [20:0] PHASE_REPL [NUM_PHASES] = '{
      21'h00FFFD, 21'h10FFFF, 21'h1FFFFF, 21'h000000, 21'h1FFFFF, 21'h0020AC
   };

   // Directed row: input byte, end marker, and the results when they are typed in
   typedef struct packed {
      logic [7:0]  byte_in;
      logic        fin;
      logic        typed;
      logic [2:0]  cnt;
      logic [20:0] ch;
      logic        bad;
   } dir_row_type;

   localparam logic [20:0] R = REPLACEMENT_RESET;

   localparam dir_row_type STIM_TABLE [25] = '{
      // ASCII extremes
      '{8'h00, 1'b0, 1'b1, 3'd1, 21'h000000, 1'b0},
      '{8'h7F, 1'b0, 1'b1, 3'd1, 21'h00007F, 1'b0},
      // invalid leads, the last one also ends the stream
      '{8'h80, 1'b0, 1'b1, 3'd1, R, 1'b1},
      '{8'hC1, 1'b0, 1'b1, 3'd1, R, 1'b1},
      '{8'hFF, 1'b1, 1'b1, 3'd1, R, 1'b1},
      // smallest two-byte character
      '{8'hC2, 1'b0, 1'b1, 3'd0, 21'h0, 1'b0},
      '{8'h80, 1'b0, 1'b1, 3'd1, 21'h000080, 1'b0},
      // first continuation just outside the tight bounds
      '{8'hE0, 1'b0, 1'b1, 3'd0, 21'h0, 1'b0},
      '{8'h9F, 1'b0, 1'b0, 3'd0, 21'h0, 1'b0},
      '{8'hED, 1'b0, 1'b1, 3'd0, 21'h0, 1'b0},
      '{8'hA0, 1'b0, 1'b0, 3'd0, 21'h0, 1'b0},
      '{8'hF0, 1'b0, 1'b1, 3'd0, 21'h0, 1'b0},
      '{8'h8F, 1'b0, 1'b0, 3'd0, 21'h0, 1'b0},
      '{8'hF4, 1'b0, 1'b1, 3'd0, 21'h0, 1'b0},
      '{8'h90, 1'b0, 1'b0, 3'd0, 21'h0, 1'b0},
      // largest code point
      '{8'hF4, 1'b0, 1'b1, 3'd0, 21'h0, 1'b0},
      '{8'h8F, 1'b0, 1'b1, 3'd0, 21'h0, 1'b0},
      '{8'hBF, 1'b0, 1'b1, 3'd0, 21'h0, 1'b0},
      '{8'hBF, 1'b0, 1'b1, 3'd1, 21'h10FFFF, 1'b0},
      // three bytes taken, then a lead that ends the stream: four replacements
      '{8'hF0, 1'b0, 1'b1, 3'd0, 21'h0, 1'b0},
      '{8'h90, 1'b0, 1'b1, 3'd0, 21'h0, 1'b0},
      '{8'h80, 1'b0, 1'b1, 3'd0, 21'h0, 1'b0},
      '{8'hC2, 1'b1, 1'b1, 3'd4, R, 1'b1},
      // stream ends inside a sequence
      '{8'hE1, 1'b0, 1'b1, 3'd0, 21'h0, 1'b0},
      '{8'h80, 1'b1, 1'b1, 3'd2, R, 1'b1}
   };

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic    csr_we = 1'b0;
   logic    csr_index = CSR_OUTPUT_MODE;
   logic [20:0] csr_wdata = '0;

   // Decoder model state and its copy of the registers
   logic        mode_q;
   logic [20:0] repl_q;
   logic [1:0]  conts_left;
   logic [1:0]  bytes_taken;
   logic [20:0] code_acc;
   logic [7:0]  cont_lo;
   logic [7:0]  cont_hi;

   rsp_type step_chars[$];
   rsp_type expected_chars[$];
   req_type byte_plan[$];

   int gap_pct = 16;
   int stall_pct = 75;
   int hold_requests = 0;
   int holds_done = 0;
   int hold_left = 0;
   int fail_count = 0;
   int cycle_count = 0;

   utf8_validating_decoder uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Decoder model
   // ---------------------------------------------------------------------------

   function automatic logic [20:0] cp1252_byte(input logic [20:0] cp);
      logic [20:0] res;
      res = QMARK;
      if (cp < 21'h80 || (cp >= 21'hA0 && cp <= 21'hFF)) begin
         res = cp;
      end else begin
         for (int k = 0; k < 32; k++) begin
            if (CP1252_HIGH[k] == cp) res = 21'h80 + 21'(k);
         end
      end
      return res;
   endfunction

   task automatic push_char(input logic [20:0] cp, input logic bad);
      rsp_type r;
      r.char_value = mode_q ? cp1252_byte(cp) : cp;
      r.malformed  = bad;
      r.run_last   = 1'b0;
      // a byte never yields more than four results
      if (step_chars.size() < 4) step_chars.insert(step_chars.size(), r);
   endtask

   task automatic clear_seq();
      conts_left  = '0;
      bytes_taken = '0;
      code_acc    = '0;
      cont_lo     = CONT_LO;
      cont_hi     = CONT_HI;
   endtask

   // One replacement per byte taken for the open sequence
   task automatic flush_taken();
      repeat (bytes_taken) push_char(repl_q, 1'b1);
      clear_seq();
   endtask

   task automatic start_lead(input logic [7:0] b, input logic fin);
      if (b <= ASCII_TOP) begin
         push_char({13'd0, b}, 1'b0);
      end else begin
         clear_seq();
         if (b >= LEAD2_LO && b <= LEAD2_HI) begin
            conts_left = 2'd1;
            code_acc   = {16'd0, b[4:0]};
         end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
            conts_left = 2'd2;
            code_acc   = {17'd0, b[3:0]};
            if (b == LEAD3_LO) cont_lo = AFTER_E0_LO;
            if (b == LEAD_ED) cont_hi = AFTER_ED_HI;
         end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
            conts_left = 2'd3;
            code_acc   = {18'd0, b[2:0]};
            if (b == LEAD4_LO) cont_lo = AFTER_F0_LO;
            if (b == LEAD4_HI) cont_hi = AFTER_F4_HI;
         end
         if (conts_left == 2'd0) begin
            push_char(repl_q, 1'b1);
         end else begin
            bytes_taken = 2'd1;
            if (fin) flush_taken();
         end
      end
   endtask

   // Results of one accepted byte land in step_chars
   task automatic decode_byte(input req_type d);
      step_chars.delete();
      if (conts_left != 2'd0) begin
         if (d.data_byte >= cont_lo && d.data_byte <= cont_hi) begin
            code_acc = {code_acc[14:0], d.data_byte[5:0]};
            conts_left--;
            cont_lo = CONT_LO;
            cont_hi = CONT_HI;
            if (conts_left == 2'd0) begin
               push_char(code_acc, 1'b0);
               clear_seq();
            end else begin
               bytes_taken++;
               if (d.stream_end) flush_taken();
            end
         end else begin
            // broken sequence: replace what was taken, then retry the byte as a lead
            flush_taken();
            start_lead(d.data_byte, d.stream_end);
         end
      end else begin
         start_lead(d.data_byte, d.stream_end);
      end
      if (step_chars.size() != 0) begin
         step_chars[step_chars.size() - 1].run_last = 1'b1;
      end
   endtask

   // ---------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------

   function automatic int utf8_len(input logic [20:0] cp);
      if (cp < 21'h80) return 1;
      if (cp < 21'h800) return 2;
      if (cp < 21'h10000) return 3;
      return 4;
   endfunction

   // Encoded bytes, first byte in the top octet
   function automatic logic [31:0] utf8_bytes(input logic [20:0] cp);
      if (cp < 21'h80) return {cp[7:0], 24'h0};
      if (cp < 21'h800) return {3'b110, cp[10:6], 2'b10, cp[5:0], 16'h0};
      if (cp < 21'h10000)
         return {4'b1110, cp[15:12], 2'b10, cp[11:6], 2'b10, cp[5:0], 8'h0};
      return {5'b11110, cp[20:18], 2'b10, cp[17:12], 2'b10, cp[11:6], 2'b10, cp[5:0]};
   endfunction

   function automatic logic [20:0] random_cp(input int cls);
      logic [20:0] v;
      case (cls)
         0: v = 21'($urandom_range(32'h7F, 0));
         1: v = 21'($urandom_range(32'h7FF, 32'h80));
         2: begin
            v = 21'($urandom_range(32'hFFFF, 32'h800));
            // surrogates are not encodable
            if (v >= 21'hD800 && v <= 21'hDFFF) v = v ^ 21'h2000;
         end
         3: v = 21'($urandom_range(32'h10FFFF, 32'h10000));
         4: v = CP1252_HIGH[$urandom_range(31)];
         default: v = 21'($urandom_range(32'hFF, 32'hA0));
      endcase
      return v;
   endfunction

   task automatic plan_bytes(input logic [31:0] seq, input int cnt, input logic fin);
      req_type r;
      for (int i = 0; i < cnt; i++) begin
         r.data_byte  = seq[31 - 8 * i -: 8];
         r.stream_end = fin && (i == cnt - 1);
         byte_plan.insert(byte_plan.size(), r);
      end
   endtask

   task automatic plan_noise();
      req_type r;
      r.data_byte  = 8'($urandom_range(255));
      r.stream_end = ($urandom_range(4) == 0);
      byte_plan.insert(byte_plan.size(), r);
   endtask

   // Mostly well-formed characters, some noise, truncations and bound probes
   task automatic plan_random_unit();
      int          pick;
      int          len;
      int          cut;
      logic [20:0] cp;
      logic [7:0]  lead;
      logic [7:0]  probe;
      pick = $urandom_range(99);
      if (pick < 60) begin
         cp = random_cp($urandom_range(5));
         plan_bytes(utf8_bytes(cp), utf8_len(cp), $urandom_range(9) == 0);
      end else if (pick < 75) begin
         plan_noise();
      end else if (pick < 90) begin
         cp  = random_cp($urandom_range(3, 1));
         len = utf8_len(cp);
         cut = $urandom_range(len - 1, 1);
         if ($urandom_range(1) == 0) begin
            plan_bytes(utf8_bytes(cp), cut, 1'b1);
         end else begin
            plan_bytes(utf8_bytes(cp), cut, 1'b0);
            plan_noise();
         end
      end else begin
         case ($urandom_range(3))
            0: lead = LEAD3_LO;
            1: lead = LEAD_ED;
            2: lead = LEAD4_LO;
            default: lead = LEAD4_HI;
         endcase
         case ($urandom_range(7))
            0: probe = ASCII_TOP;
            1: probe = CONT_LO;
            2: probe = AFTER_F4_HI;
            3: probe = AFTER_F0_LO;
            4: probe = AFTER_ED_HI;
            5: probe = AFTER_E0_LO;
            6: probe = CONT_HI;
            default: probe = CONT_HI + 8'd1;
         endcase
         plan_bytes({lead, probe, 8'($urandom_range(8'hBF, 8'h80)),
                     8'($urandom_range(8'hBF, 8'h80))}, 4, 1'b0);
      end
   endtask

   // Present one transaction after a random gap and wait until it is taken
   task automatic offer(input req_type d);
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= d;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic apply_settings(input logic m, input logic [20:0] v);
      csr_we    <= 1'b1;
      csr_index <= CSR_OUTPUT_MODE;
      csr_wdata <= {20'd0, m};
      @(posedge clock);
      csr_index <= CSR_REPLACEMENT_CODE;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      mode_q = m;
      repl_q = v;
   endtask

   // ---------------------------------------------------------------------------
   // Result checking and receiver stalls
   // ---------------------------------------------------------------------------

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_chars.size() == 0) begin
            $error("unexpected result: char_value %h malformed %b run_last %b",
                   rsp_data.char_value, rsp_data.malformed, rsp_data.run_last);
            fail_count++;
         end else begin
            want = expected_chars.pop_front();
            if (rsp_data.char_value !== want.char_value) begin
               $error("char_value: expected %h, got %h", want.char_value,
                      rsp_data.char_value);
               fail_count++;
            end
            if (rsp_data.malformed !== want.malformed) begin
               $error("malformed: expected %b, got %b", want.malformed, rsp_data.malformed);
               fail_count++;
            end
            if (rsp_data.run_last !== want.run_last) begin
               $error("run_last: expected %b, got %b", want.run_last, rsp_data.run_last);
               fail_count++;
            end
         end
      end
      // long hold-off on request, otherwise random stalls
      if (holds_done != hold_requests) begin
         holds_done++;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // ---------------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------------

   initial begin
      req_type r;
      rsp_type t;
      mode_q = 1'b0;
      repl_q = REPLACEMENT_RESET;
      clear_seq();

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed table at reset settings
      foreach (STIM_TABLE[i]) begin
         r.data_byte  = STIM_TABLE[i].byte_in;
         r.stream_end = STIM_TABLE[i].fin;
         offer(r);
         decode_byte(r);
         if (STIM_TABLE[i].typed) begin
            for (int k = 0; k < STIM_TABLE[i].cnt; k++) begin
               t.char_value = STIM_TABLE[i].ch;
               t.malformed  = STIM_TABLE[i].bad;
               t.run_last   = (k == STIM_TABLE[i].cnt - 1);
               expected_chars.insert(expected_chars.size(), t);
            end
         end else begin
            foreach (step_chars[k])
               expected_chars.insert(expected_chars.size(), step_chars[k]);
         end
      end
      req_valid <= 1'b0;

      // Random phases; settings change only once the decoder has drained
      for (int p = 0; p < NUM_PHASES; p++) begin
         while (expected_chars.size() != 0) @(posedge clock);
         repeat (DRAIN_CYCLES) @(posedge clock);
         apply_settings(PHASE_MODE[p], PHASE_REPL[p]);
         if (p < 2) begin
            gap_pct   = 16;
            stall_pct = 75;
         end else if (p < 4) begin
            gap_pct   = 75;
            stall_pct = 16;
         end else begin
            gap_pct   = 0;
            stall_pct = 0;
         end
         // receiver backs off while the sender keeps streaming
         if (p == 4) hold_requests++;
         while (byte_plan.size() < PHASE_ITEMS) plan_random_unit();
         while (byte_plan.size() != 0) begin
            r = byte_plan.pop_front();
            offer(r);
            decode_byte(r);
            foreach (step_chars[k])
               expected_chars.insert(expected_chars.size(), step_chars[k]);
         end
         req_valid <= 1'b0;
      end

      while (expected_chars.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
